/* rtl/wmva_pkg.sv */
// Package for the weighted mean and variance accumulator.
// Holds field widths, command and status codes, sequencer types and the
// controller/datapath interface structs. Depends on nothing.
`default_nettype none

package wmva_pkg;

  // Parameter defaults.
  localparam int COUNT_BITS_DEF       = 16;
  localparam int VALUE_FRAC_BITS_DEF  = 8;
  localparam int WEIGHT_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int VALUE_W   = 16;
  localparam int WEIGHT_W  = 12;
  localparam int MEAN_W    = 24;
  localparam int VAR_W     = 40;
  localparam int CNT_OUT_W = 16;
  localparam int STATUS_W  = 2;
  localparam int OUT_FRAC  = 16;
  localparam int MUL_DIG_W = 8;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = MEAN_W + 5 * VAR_W + CNT_OUT_W;

  // Item products: w*v, v*v (as magnitude), w*w, w*v*v.
  localparam int WV_W  = WEIGHT_W + 1 + VALUE_W;
  localparam int VV_W  = 2 * VALUE_W - 1;
  localparam int WW_W  = 2 * WEIGHT_W;
  localparam int WVV_W = WEIGHT_W + VV_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_PROBE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Arithmetic steps, run in this order for every item.
  typedef enum logic [3:0] {
    OP_MUL_QW,
    OP_MUL_SS,
    OP_MUL_WW,
    OP_DIV_MEAN,
    OP_DIV_SV,
    OP_DIV_MV,
    OP_DIV_WMV,
    OP_MUL_QL,
    OP_MUL_SL,
    OP_MUL_LW,
    OP_DIV_OSV,
    OP_DIV_OMV
  } op_t;

  localparam op_t OP_FIRST = OP_MUL_QW;
  localparam op_t OP_LAST  = OP_DIV_OMV;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_UPDATE,
    ST_PREP,
    ST_LAUNCH,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic calc_prod;
    logic calc_scale;
    logic update;
    logic prep;
    logic start_mul;
    logic start_div;
    logic commit;
    logic load_out;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic op_run;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

  function automatic logic op_is_mul(op_t op);
    logic r;
    r = 1'b0;
    unique case (op) inside
      OP_MUL_QW, OP_MUL_SS, OP_MUL_WW, OP_MUL_QL, OP_MUL_SL, OP_MUL_LW: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/wmva_mul.sv */
// Digit-serial multiplier: one 8-bit digit of b per cycle.
// Uses wmva_pkg for the digit width.
`default_nettype none

module wmva_mul #(
  parameter int A_W = 60,
  parameter int B_W = 45,
  parameter int P_W = 90
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  output logic                done,
  output logic [P_W-1:0]      prod
);

  localparam int DIG = wmva_pkg::MUL_DIG_W;

  logic           busy;
  logic [P_W-1:0] a_sh;
  logic [B_W-1:0] b_rem;
  logic [P_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (b_rem == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= P_W'(a);
      b_rem <= b;
      acc   <= '0;
    end else if (busy && (b_rem != '0)) begin
      acc   <= acc + P_W'(a_sh * b_rem[DIG-1:0]);
      a_sh  <= a_sh << DIG;
      b_rem <= b_rem >> DIG;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

/* rtl/wmva_div.sv */
// Restoring divider, one quotient bit per cycle; sat flags overflow of Q_W bits.
// Standalone; no package use.
`default_nettype none

module wmva_div #(
  parameter int N_W = 104,
  parameter int D_W = 73,
  parameter int Q_W = 40
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [N_W-1:0] num,
  input  wire logic [D_W-1:0] den,
  output logic                done,
  output logic                sat,
  output logic [Q_W-1:0]      quo
);

  localparam int HI_W  = N_W - Q_W;
  localparam int CMP_W = HI_W + D_W + 1;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dreg;
  logic [Q_W-1:0]   qr;
  logic             sat_now;
  logic [D_W:0]     trial;
  logic             ge;

  // The quotient fits Q_W bits only when the top part of num is below den.
  assign sat_now = CMP_W'(num[N_W-1:Q_W]) >= CMP_W'(den);
  assign trial   = {rem, qr[Q_W-1]};
  assign ge      = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat_now) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(Q_W);
        end
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat  <= sat_now;
      rem  <= D_W'(num[N_W-1:Q_W]);
      qr   <= num[Q_W-1:0];
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? D_W'(trial - {1'b0, dreg}) : D_W'(trial);
      qr  <= {qr[Q_W-2:0], ge};
    end
  end

  assign quo = qr;

endmodule

`default_nettype wire

/* rtl/wmva_datapath.sv */
// Datapath: running sums, item products, operand selection, result and output registers.
// Uses wmva_pkg and instantiates wmva_mul and wmva_div.
`default_nettype none

module wmva_datapath #(
  parameter int COUNT_BITS       = wmva_pkg::COUNT_BITS_DEF,
  parameter int VALUE_FRAC_BITS  = wmva_pkg::VALUE_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = wmva_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire wmva_pkg::dp_cmd_t                    cmd,
  output wmva_pkg::dp_stat_t                        stat,
  input  wire logic [wmva_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic signed [wmva_pkg::VALUE_W-1:0]  obs_value,
  input  wire logic [wmva_pkg::WEIGHT_W-1:0]        obs_weight,
  output logic signed [wmva_pkg::MEAN_W-1:0]        weighted_mean,
  output logic [wmva_pkg::VAR_W-1:0]                sample_variance,
  output logic [wmva_pkg::VAR_W-1:0]                mean_variance,
  output logic [wmva_pkg::VAR_W-1:0]                weight_mean_variance,
  output logic [wmva_pkg::VAR_W-1:0]                omit_sample_variance,
  output logic [wmva_pkg::VAR_W-1:0]                omit_mean_variance,
  output logic [wmva_pkg::CNT_OUT_W-1:0]            item_count,
  output logic [wmva_pkg::STATUS_W-1:0]             status
);

  localparam int VALUE_W = wmva_pkg::VALUE_W;
  localparam int WEIGHT_W = wmva_pkg::WEIGHT_W;
  localparam int VAR_W   = wmva_pkg::VAR_W;
  localparam int MEAN_W  = wmva_pkg::MEAN_W;
  localparam int WV_W    = wmva_pkg::WV_W;
  localparam int VV_W    = wmva_pkg::VV_W;
  localparam int WW_W    = wmva_pkg::WW_W;
  localparam int WVV_W   = wmva_pkg::WVV_W;

  localparam int WSUM_W = WEIGHT_W + COUNT_BITS;
  localparam int WSQ_W  = 2 * WEIGHT_W + COUNT_BITS;
  localparam int VSUM_W = WEIGHT_W + VALUE_W + COUNT_BITS;
  localparam int QSUM_W = WEIGHT_W + 2 * VALUE_W + COUNT_BITS;
  localparam int A_W    = QSUM_W;
  localparam int B_W    = VSUM_W + 1;
  localparam int PROD_W = 2 * (VSUM_W + 1);
  localparam int NUM_W  = QSUM_W + WSUM_W + wmva_pkg::OUT_FRAC;
  localparam int DEN_W  = 2 * WSUM_W + 1 + 2 * VALUE_FRAC_BITS;

  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_POS = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_NEG = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [NUM_W-1:0]  RECIP_ONE = NUM_W'(1) << (wmva_pkg::OUT_FRAC + WEIGHT_FRAC_BITS);

  // Item registers.
  wmva_pkg::cmd_t             cmd_r;
  logic signed [VALUE_W-1:0]  v_r;
  logic [WEIGHT_W-1:0]        w_r;
  logic signed [WV_W-1:0]     wv_r;
  logic [VV_W-1:0]            vv_r;
  logic [WW_W-1:0]            ww_r;
  logic [WVV_W-1:0]           wvv_r;
  logic signed [2*VALUE_W-1:0] vv_full;

  // Running sums.
  logic [WSUM_W-1:0]     wsum;
  logic [WSQ_W-1:0]      wsq;
  logic [VSUM_W-1:0]     vsum;
  logic [QSUM_W-1:0]     qsum;
  logic [COUNT_BITS-1:0] cnt;
  wmva_pkg::status_t     stat_r;

  // Values derived once the sums are final.
  logic              s_neg;
  logic [VSUM_W-1:0] sab;
  logic [VSUM_W:0]   sl;
  logic              wl_pos;
  logic [WSUM_W-1:0] wl_mag;
  logic              q_ok;
  logic [QSUM_W-1:0] qomit;
  logic [WSUM_W:0]   wl_c;
  logic [VSUM_W:0]   sdiff;

  // Intermediate products.
  logic [PROD_W-1:0] np;
  logic [PROD_W-1:0] nn;
  logic [PROD_W-1:0] dp;
  logic [PROD_W-1:0] dp_omit;

  // Results of the current item.
  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  sv_r;
  logic [VAR_W-1:0]  mv_r;
  logic [VAR_W-1:0]  wmv_r;
  logic [VAR_W-1:0]  osv_r;
  logic [VAR_W-1:0]  omv_r;

  // Unit interface.
  logic [A_W-1:0]    mul_a;
  logic [B_W-1:0]    mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              mul_done;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic              div_sat;
  logic [VAR_W-1:0]  div_quo;

  logic n_gt1, n_gt2, n_eq2, n_nz, w_nz, omit_full;
  logic np_gt, dp_gt, dpo_gt, run;
  logic [VAR_W-1:0]  var_c;
  logic [MEAN_W-1:0] mean_lim;
  logic [MEAN_W-1:0] mean_mag;
  logic [MEAN_W-1:0] mean_c;

  assign vv_full = v_r * v_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= wmva_pkg::cmd_t'(in_cmd);
      v_r   <= obs_value;
      w_r   <= obs_weight;
    end
    if (cmd.calc_prod) begin
      wv_r <= $signed({1'b0, w_r}) * v_r;
      vv_r <= vv_full[VV_W-1:0];
      ww_r <= w_r * w_r;
    end
    if (cmd.calc_scale) begin
      wvv_r <= w_r * vv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum   <= '0;
      wsq    <= '0;
      vsum   <= '0;
      qsum   <= '0;
      cnt    <= '0;
      stat_r <= wmva_pkg::STAT_OK;
    end else if (cmd.update) begin
      stat_r <= wmva_pkg::STAT_OK;
      unique case (cmd_r)
        wmva_pkg::CMD_ADD: begin
          if (&cnt) begin
            stat_r <= wmva_pkg::STAT_FULL;
          end else begin
            wsum <= wsum + WSUM_W'(w_r);
            wsq  <= wsq + WSQ_W'(ww_r);
            vsum <= vsum + {{(VSUM_W-WV_W){wv_r[WV_W-1]}}, wv_r};
            qsum <= qsum + QSUM_W'(wvv_r);
            cnt  <= cnt + COUNT_BITS'(1);
          end
        end
        wmva_pkg::CMD_SUB: begin
          if (cnt == '0) begin
            stat_r <= wmva_pkg::STAT_EMPTY;
          end else begin
            wsum <= wsum - WSUM_W'(w_r);
            wsq  <= wsq - WSQ_W'(ww_r);
            vsum <= vsum - {{(VSUM_W-WV_W){wv_r[WV_W-1]}}, wv_r};
            qsum <= qsum - QSUM_W'(wvv_r);
            cnt  <= cnt - COUNT_BITS'(1);
          end
        end
        wmva_pkg::CMD_CLEAR: begin
          wsum <= '0;
          wsq  <= '0;
          vsum <= '0;
          qsum <= '0;
          cnt  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wl_c  = {1'b0, wsum} - (WSUM_W+1)'(w_r);
  assign sdiff = {vsum[VSUM_W-1], vsum} - {{(VSUM_W+1-WV_W){wv_r[WV_W-1]}}, wv_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      s_neg  <= vsum[VSUM_W-1];
      sab    <= vsum[VSUM_W-1] ? (~vsum + VSUM_W'(1)) : vsum;
      sl     <= sdiff[VSUM_W] ? (~sdiff + (VSUM_W+1)'(1)) : sdiff;
      wl_pos <= !wl_c[WSUM_W] && (wl_c != '0);
      wl_mag <= wl_c[WSUM_W-1:0];
      q_ok   <= qsum >= QSUM_W'(wvv_r);
      qomit  <= qsum - QSUM_W'(wvv_r);
    end
  end

  assign n_gt1     = cnt > COUNT_BITS'(1);
  assign n_gt2     = cnt > COUNT_BITS'(2);
  assign n_eq2     = cnt == COUNT_BITS'(2);
  assign n_nz      = cnt != '0;
  assign w_nz      = wsum != '0;
  assign omit_full = wl_pos && n_gt2 && q_ok;
  assign dp_omit   = dp + PROD_W'(ww_r);
  assign np_gt     = np > nn;
  assign dp_gt     = dp > PROD_W'(wsq);
  assign dpo_gt    = dp_omit > PROD_W'(wsq);

  always_comb begin
    run     = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    unique case (cmd.op)
      wmva_pkg::OP_MUL_QW: begin
        run = 1'b1; mul_a = qsum; mul_b = B_W'(wsum);
      end
      wmva_pkg::OP_MUL_SS: begin
        run = 1'b1; mul_a = A_W'(sab); mul_b = B_W'(sab);
      end
      wmva_pkg::OP_MUL_WW: begin
        run = 1'b1; mul_a = A_W'(wsum); mul_b = B_W'(wsum);
      end
      wmva_pkg::OP_DIV_MEAN: begin
        run     = w_nz;
        div_num = NUM_W'(sab) << wmva_pkg::OUT_FRAC;
        div_den = DEN_W'(wsum) << VALUE_FRAC_BITS;
      end
      wmva_pkg::OP_DIV_SV: begin
        run     = n_gt1 && np_gt && dp_gt;
        div_num = NUM_W'(np - nn) << wmva_pkg::OUT_FRAC;
        div_den = DEN_W'(dp - PROD_W'(wsq)) << (2 * VALUE_FRAC_BITS);
      end
      wmva_pkg::OP_DIV_MV: begin
        run     = n_gt1;
        div_num = NUM_W'(sv_r);
        div_den = DEN_W'(cnt);
      end
      wmva_pkg::OP_DIV_WMV: begin
        run     = n_nz && w_nz;
        div_num = RECIP_ONE;
        div_den = DEN_W'(wsum);
      end
      wmva_pkg::OP_MUL_QL: begin
        run = omit_full; mul_a = qomit; mul_b = B_W'(wl_mag);
      end
      wmva_pkg::OP_MUL_SL: begin
        run = omit_full; mul_a = A_W'(sl); mul_b = B_W'(sl);
      end
      wmva_pkg::OP_MUL_LW: begin
        run = omit_full; mul_a = A_W'(wl_mag); mul_b = B_W'(wl_mag);
      end
      wmva_pkg::OP_DIV_OSV: begin
        if (omit_full) begin
          run     = np_gt && dpo_gt;
          div_num = NUM_W'(np - nn) << wmva_pkg::OUT_FRAC;
          div_den = DEN_W'(dp_omit - PROD_W'(wsq)) << (2 * VALUE_FRAC_BITS);
        end else begin
          // Two items in the sums, positive weight once this one is left out: reciprocal only.
          run     = wl_pos && n_eq2;
          div_num = RECIP_ONE;
          div_den = DEN_W'(wl_mag);
        end
      end
      wmva_pkg::OP_DIV_OMV: begin
        run     = n_gt2;
        div_num = NUM_W'(osv_r);
        div_den = DEN_W'(cnt - COUNT_BITS'(1));
      end
      default: begin
      end
    endcase
  end

  assign var_c    = div_sat ? VAR_MAX : div_quo;
  assign mean_lim = s_neg ? MEAN_NEG : MEAN_POS;
  assign mean_mag = (div_sat || (div_quo > VAR_W'(mean_lim))) ? mean_lim : div_quo[MEAN_W-1:0];
  assign mean_c   = s_neg ? (~mean_mag + MEAN_W'(1)) : mean_mag;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (cmd.op) inside
        wmva_pkg::OP_MUL_QW, wmva_pkg::OP_MUL_QL: if (run) np <= mul_prod;
        wmva_pkg::OP_MUL_SS, wmva_pkg::OP_MUL_SL: if (run) nn <= mul_prod;
        wmva_pkg::OP_MUL_WW, wmva_pkg::OP_MUL_LW: if (run) dp <= mul_prod;
        wmva_pkg::OP_DIV_MEAN: mean_r <= run ? mean_c : '0;
        wmva_pkg::OP_DIV_SV:   sv_r   <= run ? var_c : '0;
        wmva_pkg::OP_DIV_MV:   mv_r   <= run ? var_c : '0;
        wmva_pkg::OP_DIV_WMV:  wmv_r  <= run ? var_c : (n_nz ? VAR_MAX : '0);
        wmva_pkg::OP_DIV_OSV:  osv_r  <= run ? var_c : '0;
        wmva_pkg::OP_DIV_OMV:  omv_r  <= run ? var_c : '0;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      weighted_mean        <= mean_r;
      sample_variance      <= sv_r;
      mean_variance        <= mv_r;
      weight_mean_variance <= wmv_r;
      omit_sample_variance <= osv_r;
      omit_mean_variance   <= omv_r;
      item_count           <= wmva_pkg::CNT_OUT_W'(cnt);
      status               <= stat_r;
    end
  end

  wmva_mul #(
    .A_W (A_W),
    .B_W (B_W),
    .P_W (PROD_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_mul),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  wmva_div #(
    .N_W (NUM_W),
    .D_W (DEN_W),
    .Q_W (VAR_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .sat   (div_sat),
    .quo   (div_quo)
  );

  assign stat.op_run   = run;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;

endmodule

`default_nettype wire

/* rtl/wmva_ctrl.sv */
// Controller: sequences the item phases and the arithmetic steps, owns the handshakes.
// Uses wmva_pkg for the state, step and interface types.
`default_nettype none

module wmva_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  output logic                    m_valid,
  input  wire logic               m_ready,
  input  wire wmva_pkg::dp_stat_t stat,
  output wmva_pkg::dp_cmd_t       cmd
);

  wmva_pkg::state_t state, state_next;
  wmva_pkg::op_t    op, op_next;
  logic             step_done;
  logic             last_op;

  assign last_op   = op == wmva_pkg::OP_LAST;
  assign step_done = ((state == wmva_pkg::ST_LAUNCH) && !stat.op_run)
                  || ((state == wmva_pkg::ST_MUL) && stat.mul_done)
                  || ((state == wmva_pkg::ST_DIV) && stat.div_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= wmva_pkg::ST_IDLE;
      op      <= wmva_pkg::OP_FIRST;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      wmva_pkg::ST_IDLE:   if (s_valid) state_next = wmva_pkg::ST_PROD;
      wmva_pkg::ST_PROD:   state_next = wmva_pkg::ST_SCALE;
      wmva_pkg::ST_SCALE:  state_next = wmva_pkg::ST_UPDATE;
      wmva_pkg::ST_UPDATE: state_next = wmva_pkg::ST_PREP;
      wmva_pkg::ST_PREP: begin
        state_next = wmva_pkg::ST_LAUNCH;
        op_next    = wmva_pkg::OP_FIRST;
      end
      wmva_pkg::ST_LAUNCH: begin
        if (stat.op_run) begin
          state_next = wmva_pkg::op_is_mul(op) ? wmva_pkg::ST_MUL : wmva_pkg::ST_DIV;
        end else if (last_op) begin
          state_next = wmva_pkg::ST_DONE;
        end else begin
          op_next = wmva_pkg::op_t'(op + 4'd1);
        end
      end
      wmva_pkg::ST_MUL, wmva_pkg::ST_DIV: begin
        if (step_done) begin
          if (last_op) begin
            state_next = wmva_pkg::ST_DONE;
          end else begin
            state_next = wmva_pkg::ST_LAUNCH;
            op_next    = wmva_pkg::op_t'(op + 4'd1);
          end
        end
      end
      wmva_pkg::ST_DONE:   if (!m_valid || m_ready) state_next = wmva_pkg::ST_IDLE;
      default:             state_next = wmva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready        = state == wmva_pkg::ST_IDLE;
    cmd.load_in    = (state == wmva_pkg::ST_IDLE) && s_valid;
    cmd.calc_prod  = state == wmva_pkg::ST_PROD;
    cmd.calc_scale = state == wmva_pkg::ST_SCALE;
    cmd.update     = state == wmva_pkg::ST_UPDATE;
    cmd.prep       = state == wmva_pkg::ST_PREP;
    cmd.start_mul  = (state == wmva_pkg::ST_LAUNCH) && stat.op_run && wmva_pkg::op_is_mul(op);
    cmd.start_div  = (state == wmva_pkg::ST_LAUNCH) && stat.op_run && !wmva_pkg::op_is_mul(op);
    cmd.commit     = step_done;
    cmd.load_out   = (state == wmva_pkg::ST_DONE) && (!m_valid || m_ready);
    cmd.op         = op;
  end

endmodule

`default_nettype wire

/* rtl/weighted_mean_variance_accumulator.sv */
// Top level of the weighted mean and variance accumulator.
// Joins wmva_ctrl and wmva_datapath; uses wmva_pkg for widths.
//
//   channel   dir  word                             side info
//   s_axis    in   tdata: value, weight             tuser: cmd
//   m_axis    out  tdata: mean, 5 variances, count  tuser: status
//
// One word at a time: the word is taken in, its products formed, the sums
// updated and the derived values prepared; then the twelve steps run in order,
// each product from up to six 8-bit digits on the digit-serial multiplier and
// each quotient on the shared radix-2 divider; steps that do not apply are
// skipped. The divider produces one quotient bit per cycle.
// rst is synchronous and clears the sums, the count and the handshakes.
// A result waits in the output register while the next word is taken in.
`default_nettype none

module weighted_mean_variance_accumulator #(
  parameter int COUNT_BITS       = wmva_pkg::COUNT_BITS_DEF,
  parameter int VALUE_FRAC_BITS  = wmva_pkg::VALUE_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = wmva_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // obs_value[15:0], obs_weight[27:16], zero pad [31:28]
  input  wire logic [wmva_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // cmd[1:0]
  input  wire logic [wmva_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // weighted_mean[23:0], sample_variance[63:24], mean_variance[103:64],
  // weight_mean_variance[143:104], omit_sample_variance[183:144],
  // omit_mean_variance[223:184], item_count[239:224]
  output logic [wmva_pkg::M_DATA_W-1:0]          m_axis_tdata,
  // status[1:0]
  output logic [wmva_pkg::STATUS_W-1:0]          m_axis_tuser
);

  wmva_pkg::dp_cmd_t  cmd;
  wmva_pkg::dp_stat_t stat;

  logic signed [wmva_pkg::MEAN_W-1:0] weighted_mean;
  logic [wmva_pkg::VAR_W-1:0]         sample_variance;
  logic [wmva_pkg::VAR_W-1:0]         mean_variance;
  logic [wmva_pkg::VAR_W-1:0]         weight_mean_variance;
  logic [wmva_pkg::VAR_W-1:0]         omit_sample_variance;
  logic [wmva_pkg::VAR_W-1:0]         omit_mean_variance;
  logic [wmva_pkg::CNT_OUT_W-1:0]     item_count;

  wmva_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  wmva_datapath #(
    .COUNT_BITS       (COUNT_BITS),
    .VALUE_FRAC_BITS  (VALUE_FRAC_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_cmd               (s_axis_tuser),
    .obs_value            (s_axis_tdata[wmva_pkg::VALUE_W-1:0]),
    .obs_weight           (s_axis_tdata[wmva_pkg::VALUE_W +: wmva_pkg::WEIGHT_W]),
    .weighted_mean        (weighted_mean),
    .sample_variance      (sample_variance),
    .mean_variance        (mean_variance),
    .weight_mean_variance (weight_mean_variance),
    .omit_sample_variance (omit_sample_variance),
    .omit_mean_variance   (omit_mean_variance),
    .item_count           (item_count),
    .status               (m_axis_tuser)
  );

  assign m_axis_tdata = {item_count, omit_mean_variance, omit_sample_variance,
                         weight_mean_variance, mean_variance, sample_variance,
                         weighted_mean};

endmodule

`default_nettype wire

/* rtl/wmva_checker.sv */
// Port-level checks for the weighted mean and variance accumulator.
// Uses wmva_pkg for widths; bound to the top level below.
`default_nettype none

module wmva_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [wmva_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic [wmva_pkg::STATUS_W-1:0] m_axis_tuser
);

  logic [39:0] sv, mv, wmv;
  logic [15:0] count;
  logic        in_word;

  assign sv      = m_axis_tdata[63:24];
  assign mv      = m_axis_tdata[103:64];
  assign wmv     = m_axis_tdata[143:104];
  assign count   = m_axis_tdata[239:224];
  assign in_word = s_axis_tvalid && s_axis_tready;

  // Only one word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_word |=> !s_axis_tready)
    else $error("input taken while a word is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_var_small: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (count < 16'd2) |-> (sv == '0) && (mv == '0))
    else $error("variance reported below two items");

  a_wmv_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (count == '0) |-> (wmv == '0))
    else $error("weight variance reported on empty sums");

  a_mv_le_sv: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> mv <= sv)
    else $error("variance of the mean exceeds sample variance");

endmodule

bind weighted_mean_variance_accumulator wmva_checker u_wmva_checker (.*);

`default_nettype wire

/* tb/weighted_mean_variance_accumulator_checker.sv */
// Checker for the weighted mean and variance accumulator: watches both stream
// channels, predicts each result from its own copy of the running sums and compares.
// Depends on wmva_pkg for field widths and the command and status codes.
module weighted_mean_variance_accumulator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [wmva_pkg::S_DATA_W-1:0]    s_axis_tdata,
  input  logic [wmva_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [wmva_pkg::M_DATA_W-1:0]    m_axis_tdata,
  input  logic [wmva_pkg::STATUS_W-1:0]    m_axis_tuser,
  output int                               pending,
  output int                               errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VFRAC = wmva_pkg::VALUE_FRAC_BITS_DEF;
  localparam int WFRAC = wmva_pkg::WEIGHT_FRAC_BITS_DEF;
  localparam logic [127:0] VAR_LIMIT = 128'hFF_FFFF_FFFF;

  typedef struct packed {
    logic [23:0]       mean;
    logic [39:0]       svar;
    logic [39:0]       mvar;
    logic [39:0]       wmvar;
    logic [39:0]       osvar;
    logic [39:0]       omvar;
    logic [15:0]       count;
    wmva_pkg::status_t status;
  } stats_t;

  logic [27:0] wsum;
  logic [39:0] wsq_sum;
  logic [43:0] wval_sum;
  logic [59:0] wsqval_sum;
  logic [15:0] obs_count;
  stats_t      stats_q[$];
  int          words_out;

  function automatic logic [39:0] sat40(logic [127:0] q);
    return (q > VAR_LIMIT) ? 40'hFF_FFFF_FFFF : q[39:0];
  endfunction

  function automatic logic [39:0] var_quotient(logic [127:0] np, logic [127:0] nn,
                                               logic [127:0] dp, logic [127:0] dn);
    if (np <= nn || dp <= dn) return '0;
    return sat40(((np - nn) << 16) / ((dp - dn) << (2 * VFRAC)));
  endfunction

  function automatic logic [39:0] reciprocal(logic [63:0] x);
    if (x == 0) return 40'hFF_FFFF_FFFF;
    return sat40((128'd1 << (16 + WFRAC)) / 128'(x));
  endfunction

  // Applies one input word to the sums and returns the statistics it yields.
  function automatic stats_t apply_word(wmva_pkg::cmd_t cmd, logic [15:0] val,
                                        logic [11:0] wt);
    logic signed [63:0] v, wv, sg, wl;
    logic [63:0]  w, wvv, sab, sl, m, lim;
    logic [127:0] q;
    stats_t r;
    v   = {{48{val[15]}}, val};
    w   = {52'b0, wt};
    wv  = $signed(w) * v;
    wvv = w * 64'(v * v);
    r = '0;
    r.status = wmva_pkg::STAT_OK;
    case (cmd)
      wmva_pkg::CMD_ADD: begin
        if (obs_count == 16'hFFFF) r.status = wmva_pkg::STAT_FULL;
        else begin
          wsum       = wsum + w[27:0];
          wsq_sum    = wsq_sum + 40'(w * w);
          wval_sum   = wval_sum + wv[43:0];
          wsqval_sum = wsqval_sum + wvv[59:0];
          obs_count  = obs_count + 1'b1;
        end
      end
      wmva_pkg::CMD_SUB: begin
        if (obs_count == 0) r.status = wmva_pkg::STAT_EMPTY;
        else begin
          wsum       = wsum - w[27:0];
          wsq_sum    = wsq_sum - 40'(w * w);
          wval_sum   = wval_sum - wv[43:0];
          wsqval_sum = wsqval_sum - wvv[59:0];
          obs_count  = obs_count - 1'b1;
        end
      end
      wmva_pkg::CMD_CLEAR: begin
        wsum = '0; wsq_sum = '0; wval_sum = '0; wsqval_sum = '0; obs_count = '0;
      end
      default: ;
    endcase
    sg  = {{20{wval_sum[43]}}, wval_sum};
    sab = (sg < 0) ? -sg : sg;
    if (wsum != 0) begin
      q   = (128'(sab) << 16) / (128'(wsum) << VFRAC);
      lim = (sg < 0) ? 64'd1 << 23 : (64'd1 << 23) - 1;
      m   = (q > 128'(lim)) ? lim : q[63:0];
      if (sg < 0) m = -m;
      r.mean = m[23:0];
    end
    if (obs_count > 1) begin
      r.svar = var_quotient(128'(wsqval_sum) * 128'(wsum), 128'(sab) * 128'(sab),
                            128'(wsum) * 128'(wsum), 128'(wsq_sum));
      r.mvar = r.svar / obs_count;
    end
    if (obs_count > 0) r.wmvar = reciprocal(64'(wsum));
    wl = 64'(wsum) - w;
    if (wl > 0) begin
      if (obs_count > 2) begin
        // Leaving out a value larger than the sums allow gives zero.
        if (64'(wsqval_sum) >= wvv) begin
          sl = (sg - wv < 0) ? -(sg - wv) : sg - wv;
          r.osvar = var_quotient(128'(64'(wsqval_sum) - wvv) * 128'(wl),
                                 128'(sl) * 128'(sl),
                                 128'(wl) * 128'(wl) + 128'(w * w), 128'(wsq_sum));
        end
      end else if (obs_count == 2) begin
        r.osvar = reciprocal(wl);
      end
    end
    if (obs_count > 2) r.omvar = r.osvar / (obs_count - 1);
    r.count = obs_count;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: word %0d: %s got 0x%0h, expected 0x%0h", $realtime, words_out, what,
             got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    stats_t exp_s, got_s;
    if (rst) begin
      wsum = '0; wsq_sum = '0; wval_sum = '0; wsqval_sum = '0; obs_count = '0;
      errors = 0;
      words_out = 0;
      stats_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        stats_q.insert(stats_q.size(),
                       apply_word(wmva_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[15:0],
                                  s_axis_tdata[27:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got_s = {m_axis_tdata[23:0], m_axis_tdata[63:24], m_axis_tdata[103:64],
                 m_axis_tdata[143:104], m_axis_tdata[183:144], m_axis_tdata[223:184],
                 m_axis_tdata[239:224], wmva_pkg::status_t'(m_axis_tuser)};
        if (stats_q.size() == 0) begin
          report("result word with nothing expected", got_s.count, '0);
        end else begin
          exp_s = stats_q.pop_front();
          if (got_s.mean != exp_s.mean) report("weighted_mean", got_s.mean, exp_s.mean);
          if (got_s.svar != exp_s.svar) report("sample_variance", got_s.svar, exp_s.svar);
          if (got_s.mvar != exp_s.mvar) report("mean_variance", got_s.mvar, exp_s.mvar);
          if (got_s.wmvar != exp_s.wmvar)
            report("weight_mean_variance", got_s.wmvar, exp_s.wmvar);
          if (got_s.osvar != exp_s.osvar)
            report("omit_sample_variance", got_s.osvar, exp_s.osvar);
          if (got_s.omvar != exp_s.omvar)
            report("omit_mean_variance", got_s.omvar, exp_s.omvar);
          if (got_s.count != exp_s.count) report("item_count", got_s.count, exp_s.count);
          if (got_s.status != exp_s.status) report("status", got_s.status, exp_s.status);
        end
        words_out++;
      end
    end
    pending = stats_q.size();
  end

endmodule

/* tb/weighted_mean_variance_accumulator_test.sv */
// Testbench top for the weighted mean and variance accumulator: clock, reset,
// directed and random input words, output stalls and the final verdict.
// Depends on wmva_pkg, the block and weighted_mean_variance_accumulator_checker.
module weighted_mean_variance_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 880;
  localparam int CYCLE_LIMIT  = 1_500_000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [wmva_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [wmva_pkg::CMD_W-1:0]      s_axis_tuser = wmva_pkg::CMD_PROBE;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [wmva_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic [wmva_pkg::STATUS_W-1:0]   m_axis_tuser;
  int                              pending, errors;
  int                              burst_left = 0;
  int                              cycles = 0;
  logic [15:0]                     held_val[$];
  logic [11:0]                     held_wt[$];

  weighted_mean_variance_accumulator dut (.*);
  weighted_mean_variance_accumulator_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_mean_variance_accumulator_test: done, errors");
      $finish;
    end
  end

  // Receiver: alternating runs of ready and stalls of random length.
  int run_left = 0, stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      m_axis_tready <= 1'b1;
      run_left--;
    end else begin
      m_axis_tready <= 1'b1;
      run_left   = $urandom_range(0, 40);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  end

  task automatic send_word(wmva_pkg::cmd_t cmd, logic [15:0] val, logic [11:0] wt);
    if (burst_left == 0) begin
      @(negedge clk) s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, wt, val};
    s_axis_tuser  = cmd;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (cmd == wmva_pkg::CMD_ADD) begin
      held_val.insert(held_val.size(), val);
      held_wt.insert(held_wt.size(), wt);
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023)) - 16'd512;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom) >> $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [11:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return 12'($urandom);
      1: return 12'($urandom_range(0, 1)) ? 12'hFFF : 12'h000;
      2: return 12'h100;
      default: return 12'($urandom_range(1, 1023));
    endcase
  endfunction

  initial begin
    int k, idx;
    @(negedge clk);
    wait (!rst);
    // Directed: empty probe, refused subtract, extremes, zero weight,
    // exactly two items, removal of an absent observation, clear.
    send_word(wmva_pkg::CMD_PROBE, 16'h0000, 12'h000);
    send_word(wmva_pkg::CMD_SUB,   16'h1234, 12'h100);
    send_word(wmva_pkg::CMD_ADD,   16'h7FFF, 12'hFFF);
    send_word(wmva_pkg::CMD_PROBE, 16'h7FFF, 12'hFFF);
    send_word(wmva_pkg::CMD_ADD,   16'h8000, 12'hFFF);
    send_word(wmva_pkg::CMD_PROBE, 16'h8000, 12'h001);
    send_word(wmva_pkg::CMD_ADD,   16'h0100, 12'h000);
    send_word(wmva_pkg::CMD_ADD,   16'hFF00, 12'h100);
    send_word(wmva_pkg::CMD_SUB,   16'h7FFF, 12'hFFF);
    send_word(wmva_pkg::CMD_SUB,   16'h0000, 12'h800);
    send_word(wmva_pkg::CMD_PROBE, 16'h7FFF, 12'h000);
    send_word(wmva_pkg::CMD_CLEAR, 16'h5555, 12'hAAA);
    send_word(wmva_pkg::CMD_ADD,   16'h0000, 12'h000);
    send_word(wmva_pkg::CMD_ADD,   16'h0000, 12'h000);
    send_word(wmva_pkg::CMD_PROBE, 16'h0000, 12'h000);
    send_word(wmva_pkg::CMD_SUB,   16'hAAAA, 12'h555);
    send_word(wmva_pkg::CMD_CLEAR, 16'h0000, 12'h000);
    send_word(wmva_pkg::CMD_ADD,   16'h0200, 12'h100);
    send_word(wmva_pkg::CMD_ADD,   16'h0400, 12'h100);
    send_word(wmva_pkg::CMD_ADD,   16'h0300, 12'h200);
    send_word(wmva_pkg::CMD_SUB,   16'h0300, 12'h200);
    send_word(wmva_pkg::CMD_CLEAR, 16'h0000, 12'h000);
    held_val.delete();
    held_wt.delete();

    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) begin
        @(negedge clk) s_axis_tvalid = 1'b0;
        burst_left = 0;
        wait (pending == 0);
      end
      case ($urandom_range(0, 39))
        0: begin
          send_word(wmva_pkg::CMD_CLEAR, pick_value(), pick_weight());
          held_val.delete();
          held_wt.delete();
        end
        1, 2: send_word(wmva_pkg::CMD_SUB, pick_value(), pick_weight());
        3, 4, 5, 6, 7, 8: begin
          // Take back an observation that was really added.
          if (held_val.size() > 0) begin
            idx = $urandom_range(0, held_val.size() - 1);
            send_word(wmva_pkg::CMD_SUB, held_val[idx], held_wt[idx]);
            held_val.delete(idx);
            held_wt.delete(idx);
          end else
            send_word(wmva_pkg::CMD_SUB, pick_value(), pick_weight());
        end
        9, 10, 11, 12, 13: send_word(wmva_pkg::CMD_PROBE, pick_value(), pick_weight());
        default: send_word(wmva_pkg::CMD_ADD, pick_value(), pick_weight());
      endcase
    end
    @(negedge clk) s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("weighted_mean_variance_accumulator_test: done, clean");
    else
      $display("weighted_mean_variance_accumulator_test: done, errors");
    $finish;
  end

endmodule
